>>> hw/rtl/beq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// beq_pkg
// Shared constants, types and a saturating increment for the button event qualifier
// ----------------------------------------------------------------------------
package beq_pkg;

    localparam int unsigned CNT_W    = 16;
    localparam int unsigned PADDR_W  = 4;
    localparam int unsigned PDATA_W  = 32;
    localparam int unsigned REG_IDX_W = 2;

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    localparam logic [CNT_W-1:0] DEBOUNCE_TICKS_RST     = CNT_W'(50);
    localparam logic [CNT_W-1:0] LONG_PRESS_TICKS_RST   = CNT_W'(1000);
    localparam logic [CNT_W-1:0] DOUBLE_PRESS_TICKS_RST = CNT_W'(300);
    localparam logic             ACTIVE_LOW_RST         = 1'b0;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_DEBOUNCE_TICKS     = 2'd0,
        REG_LONG_PRESS_TICKS   = 2'd1,
        REG_DOUBLE_PRESS_TICKS = 2'd2,
        REG_ACTIVE_LOW         = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic held_level;
        logic press_event;
        logic release_event;
        logic long_press_event;
        logic double_press_event;
        logic toggle_level;
    } event_t;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        logic [CNT_W-1:0] r;
        r = (v == CNT_MAX) ? CNT_MAX : v + CNT_W'(1);
        return r;
    endfunction

endpackage

>>> hw/rtl/beq_tick_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// beq_tick_if
// Tick channel carrying the raw button pin level
// ----------------------------------------------------------------------------
interface beq_tick_if;

    logic valid;
    logic ready;
    logic raw_level;

    modport source (output valid, output raw_level, input ready);
    modport sink   (input valid, input raw_level, output ready);

endinterface

>>> hw/rtl/beq_event_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// beq_event_if
// Result channel carrying the debounced level and event flags
// ----------------------------------------------------------------------------
interface beq_event_if;

    logic valid;
    logic ready;
    logic held_level;
    logic press_event;
    logic release_event;
    logic long_press_event;
    logic double_press_event;
    logic toggle_level;

    modport source (
        output valid, output held_level, output press_event, output release_event,
        output long_press_event, output double_press_event, output toggle_level,
        input ready
    );
    modport sink (
        input valid, input held_level, input press_event, input release_event,
        input long_press_event, input double_press_event, input toggle_level,
        output ready
    );

endinterface

>>> hw/rtl/button_event_qualifier_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_event_qualifier_top
// Debounce, edge, long press, double press and toggle for one push button
// ----------------------------------------------------------------------------
// One tick transfer in gives one event transfer out. A tick is captured in an
// input register; when it advances, the debounce, hold and double-press
// counters are updated and the result is written to the output register.
// A new tick is taken every cycle while the result side keeps up. Registers:
// 0x0 debounce_ticks, 0x4 long_press_ticks, 0x8 double_press_ticks, 0xC
// active_low; write them only while idle.
module button_event_qualifier_top (
    input  logic                         clk,
    input  logic                         rst_n,
    beq_tick_if.sink                     tick_in,
    beq_event_if.source                  event_out,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [beq_pkg::PADDR_W-1:0]  paddr,
    input  logic [beq_pkg::PDATA_W-1:0]  pwdata,
    output logic [beq_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready
);

    localparam int unsigned W = beq_pkg::CNT_W;

    // configuration
    logic [W-1:0] debounce_ticks_reg;
    logic [W-1:0] long_press_ticks_reg;
    logic [W-1:0] double_press_ticks_reg;
    logic         active_low_reg;
    logic         cfg_write;
    beq_pkg::reg_idx_t cfg_idx;

    // pipeline control
    logic         in_valid_reg;
    logic         raw_reg;
    logic         out_valid_reg;
    beq_pkg::event_t out_reg;
    logic         advance;

    // tick state
    logic [W-1:0] sample_age_reg,        sample_age_next;
    logic         debounced_reg,         debounced_next;
    logic         previous_level_reg,    previous_level_next;
    logic         hold_timing_reg,       hold_timing_next;
    logic [W-1:0] hold_age_reg,          hold_age_next;
    logic         awaiting_second_reg,   awaiting_second_next;
    logic [W-1:0] since_first_press_reg, since_first_press_next;
    logic         toggle_bit_reg,        toggle_bit_next;
    beq_pkg::event_t ev_next;

    logic [W-1:0] age;
    logic         press;
    logic         release_ev;
    logic         long_ev;
    logic         double_ev;
    logic [W-1:0] sfp_age;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign cfg_idx   = beq_pkg::reg_idx_t'(paddr[beq_pkg::REG_IDX_W+1:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_ticks_reg     <= beq_pkg::DEBOUNCE_TICKS_RST;
            long_press_ticks_reg   <= beq_pkg::LONG_PRESS_TICKS_RST;
            double_press_ticks_reg <= beq_pkg::DOUBLE_PRESS_TICKS_RST;
            active_low_reg         <= beq_pkg::ACTIVE_LOW_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_idx)
                beq_pkg::REG_DEBOUNCE_TICKS:     debounce_ticks_reg     <= pwdata[W-1:0];
                beq_pkg::REG_LONG_PRESS_TICKS:   long_press_ticks_reg   <= pwdata[W-1:0];
                beq_pkg::REG_DOUBLE_PRESS_TICKS: double_press_ticks_reg <= pwdata[W-1:0];
                beq_pkg::REG_ACTIVE_LOW:         active_low_reg         <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            beq_pkg::REG_DEBOUNCE_TICKS:
                prdata = {{(beq_pkg::PDATA_W-W){1'b0}}, debounce_ticks_reg};
            beq_pkg::REG_LONG_PRESS_TICKS:
                prdata = {{(beq_pkg::PDATA_W-W){1'b0}}, long_press_ticks_reg};
            beq_pkg::REG_DOUBLE_PRESS_TICKS:
                prdata = {{(beq_pkg::PDATA_W-W){1'b0}}, double_press_ticks_reg};
            beq_pkg::REG_ACTIVE_LOW:
                prdata = {{(beq_pkg::PDATA_W-1){1'b0}}, active_low_reg};
            default:
                prdata = '0;
        endcase
    end

    // handshake: output register parts the two sides
    assign advance       = in_valid_reg && (!out_valid_reg || event_out.ready);
    assign tick_in.ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (tick_in.ready)
                in_valid_reg <= tick_in.valid;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (event_out.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tick_in.valid && tick_in.ready)
            raw_reg <= tick_in.raw_level;
        if (advance)
            out_reg <= ev_next;
    end

    // per-tick update
    always_comb
    begin
        age = beq_pkg::sat_inc(sample_age_reg);
        if (age >= debounce_ticks_reg)
        begin
            debounced_next  = raw_reg ^ active_low_reg;
            sample_age_next = '0;
        end
        else
        begin
            debounced_next  = debounced_reg;
            sample_age_next = age;
        end

        press               = debounced_next & ~previous_level_reg;
        release_ev          = ~debounced_next & previous_level_reg;
        previous_level_next = debounced_next;

        long_ev = 1'b0;
        if (debounced_next)
        begin
            if (!hold_timing_reg)
            begin
                hold_timing_next = 1'b1;
                hold_age_next    = '0;
            end
            else
            begin
                hold_timing_next = 1'b1;
                hold_age_next    = beq_pkg::sat_inc(hold_age_reg);
            end
            if (hold_age_next >= long_press_ticks_reg)
            begin
                long_ev          = 1'b1;
                hold_timing_next = 1'b0;
            end
        end
        else
        begin
            hold_timing_next = 1'b0;
            hold_age_next    = hold_age_reg;
        end

        double_ev = 1'b0;
        sfp_age   = awaiting_second_reg ? beq_pkg::sat_inc(since_first_press_reg)
                                        : since_first_press_reg;
        awaiting_second_next   = awaiting_second_reg;
        since_first_press_next = sfp_age;
        if (press)
        begin
            if (awaiting_second_reg && (sfp_age <= double_press_ticks_reg))
            begin
                double_ev            = 1'b1;
                awaiting_second_next = 1'b0;
            end
            else
            begin
                since_first_press_next = '0;
                awaiting_second_next   = 1'b1;
            end
        end
        if (awaiting_second_next && (since_first_press_next > double_press_ticks_reg))
            awaiting_second_next = 1'b0;

        toggle_bit_next = toggle_bit_reg ^ press;

        ev_next.held_level         = debounced_next;
        ev_next.press_event        = press;
        ev_next.release_event      = release_ev;
        ev_next.long_press_event   = long_ev;
        ev_next.double_press_event = double_ev;
        ev_next.toggle_level       = toggle_bit_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_age_reg        <= '0;
            debounced_reg         <= 1'b0;
            previous_level_reg    <= 1'b0;
            hold_timing_reg       <= 1'b0;
            hold_age_reg          <= '0;
            awaiting_second_reg   <= 1'b0;
            since_first_press_reg <= '0;
            toggle_bit_reg        <= 1'b0;
        end
        else if (advance)
        begin
            sample_age_reg        <= sample_age_next;
            debounced_reg         <= debounced_next;
            previous_level_reg    <= previous_level_next;
            hold_timing_reg       <= hold_timing_next;
            hold_age_reg          <= hold_age_next;
            awaiting_second_reg   <= awaiting_second_next;
            since_first_press_reg <= since_first_press_next;
            toggle_bit_reg        <= toggle_bit_next;
        end
    end

    assign event_out.valid              = out_valid_reg;
    assign event_out.held_level         = out_reg.held_level;
    assign event_out.press_event        = out_reg.press_event;
    assign event_out.release_event      = out_reg.release_event;
    assign event_out.long_press_event   = out_reg.long_press_event;
    assign event_out.double_press_event = out_reg.double_press_event;
    assign event_out.toggle_level       = out_reg.toggle_level;

    // checks
    a_edge_excl: assert property (@(posedge clk) disable iff (!rst_n)
        event_out.valid |-> !(event_out.press_event && event_out.release_event))
        else $error("press and release in the same transfer");

    a_press_held: assert property (@(posedge clk) disable iff (!rst_n)
        (event_out.valid && event_out.press_event) |-> event_out.held_level)
        else $error("press event without held level");

    a_long_held: assert property (@(posedge clk) disable iff (!rst_n)
        (event_out.valid && event_out.long_press_event) |-> event_out.held_level)
        else $error("long press while released");

    a_double_press: assert property (@(posedge clk) disable iff (!rst_n)
        (event_out.valid && event_out.double_press_event) |-> event_out.press_event)
        else $error("double press without press");

    a_state_frozen: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(toggle_bit_reg) && $stable(sample_age_reg))
        else $error("tick state moved without a tick");

endmodule
